### hw/rtl/msqs_pkg.sv
// Shared types, widths and codes for the multi stack / queue store.
`default_nettype none

package msqs_pkg;

   // Default sizing of the top level
   localparam int MEM_DEPTH_DEF  = 256;
   localparam int MAX_STACKS_DEF = 8;
   localparam int MAX_QUEUES_DEF = 8;

   // Field and register widths
   localparam int WORD_W     = 32;
   localparam int MODE_W     = 2;
   localparam int TARGET_W   = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 4;
   localparam int SEG_W      = 9;
   localparam int FILL_W     = 9;
   localparam int PTR_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Largest usable segment
   localparam int SEG_MAX = 256;

   // Register reset values
   localparam int STACK_COUNT_RST   = 1;
   localparam int QUEUE_COUNT_RST   = 1;
   localparam int SEGMENT_WORDS_RST = 128;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_ENQ  = 2'd2,
      MODE_DEQ  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STACK_COUNT   = 2'd0,
      CSR_QUEUE_COUNT   = 2'd1,
      CSR_SEGMENT_WORDS = 2'd2
   } csr_idx_type;

   // Per-operation control traveling down the pipeline
   typedef struct packed {
      logic       vld;
      logic       rd_en;
      logic       wr_en;
      status_type status;
   } op_type;

endpackage

`default_nettype wire

### hw/rtl/msqs_if.sv
// Request and response channel interfaces of the stack / queue store.
`default_nettype none

interface msqs_req_if;
   import msqs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [TARGET_W-1:0]        target;
   logic signed [WORD_W-1:0]   write_word;

   modport source (output valid, output mode, output target, output write_word,
                   input ready);
   modport sink   (input valid, input mode, input target, input write_word,
                   output ready);
endinterface

interface msqs_rsp_if;
   import msqs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [WORD_W-1:0]   read_word;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, output read_word, output status, input ready);
   modport sink   (input valid, input read_word, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/msqs_ctrl.sv
// Input register, config registers, per-structure fill/pointer state and decision.
`default_nettype none

module msqs_ctrl #(
   parameter int MAX_STACKS = msqs_pkg::MAX_STACKS_DEF,
   parameter int MAX_QUEUES = msqs_pkg::MAX_QUEUES_DEF,
   parameter int SEG_IDX_W  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                csr_we,
   input  logic [msqs_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [msqs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_vld,
   input  logic [msqs_pkg::MODE_W-1:0]         req_mode,
   input  logic [msqs_pkg::TARGET_W-1:0]       req_target,
   input  logic signed [msqs_pkg::WORD_W-1:0]  req_word,
   output msqs_pkg::op_type                    op_ff,
   output logic [SEG_IDX_W-1:0]                seg_idx_ff,
   output logic [msqs_pkg::PTR_W-1:0]          offset_ff,
   output logic signed [msqs_pkg::WORD_W-1:0]  word_ff,
   output logic [msqs_pkg::SEG_W-1:0]          seg_eff
);
   import msqs_pkg::*;

   localparam int SIW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int QIW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

   // config
   logic [COUNT_W-1:0] stack_cnt_ff;
   logic [COUNT_W-1:0] queue_cnt_ff;
   logic [SEG_W-1:0]   seg_words_ff;

   // input register
   logic                     in_vld_ff;
   logic [MODE_W-1:0]        in_mode_ff;
   logic [TARGET_W-1:0]      in_target_ff;
   logic signed [WORD_W-1:0] in_word_ff;

   // structure state
   logic [FILL_W-1:0] stack_fill_ff [MAX_STACKS];
   logic [FILL_W-1:0] stack_fill_in [MAX_STACKS];
   logic [PTR_W-1:0]  queue_head_ff [MAX_QUEUES];
   logic [PTR_W-1:0]  queue_head_in [MAX_QUEUES];
   logic [PTR_W-1:0]  queue_tail_ff [MAX_QUEUES];
   logic [PTR_W-1:0]  queue_tail_in [MAX_QUEUES];
   logic [FILL_W-1:0] queue_fill_ff [MAX_QUEUES];
   logic [FILL_W-1:0] queue_fill_in [MAX_QUEUES];

   logic [COUNT_W-1:0]   stk_eff;
   logic [COUNT_W-1:0]   que_eff;
   logic [SIW-1:0]       s_idx;
   logic [QIW-1:0]       q_idx;
   logic [FILL_W-1:0]    s_fill;
   logic [FILL_W-1:0]    s_fill_dec;
   logic [FILL_W-1:0]    q_fill;
   logic [PTR_W-1:0]     q_head;
   logic [PTR_W-1:0]     q_tail;
   logic                 stk_bad;
   logic                 que_bad;
   op_type               op_in;
   logic [SEG_IDX_W-1:0] seg_idx_in;
   logic [PTR_W-1:0]     offset_in;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                  input logic [SEG_W-1:0] seg);
      logic [PTR_W:0] n;
      n = {1'b0, p} + (PTR_W+1)'(1);
      return (n >= seg) ? '0 : n[PTR_W-1:0];
   endfunction

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_cnt_ff <= COUNT_W'(STACK_COUNT_RST);
         queue_cnt_ff <= COUNT_W'(QUEUE_COUNT_RST);
         seg_words_ff <= SEG_W'(SEGMENT_WORDS_RST);
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_STACK_COUNT:   stack_cnt_ff <= csr_data[COUNT_W-1:0];
            CSR_QUEUE_COUNT:   queue_cnt_ff <= csr_data[COUNT_W-1:0];
            CSR_SEGMENT_WORDS: seg_words_ff <= csr_data[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped config
   always_comb begin
      if (seg_words_ff == '0) begin
         seg_eff = SEG_W'(1);
      end else if (seg_words_ff > SEG_W'(SEG_MAX)) begin
         seg_eff = SEG_W'(SEG_MAX);
      end else begin
         seg_eff = seg_words_ff;
      end
   end

   assign stk_eff = (int'(stack_cnt_ff) > MAX_STACKS) ? COUNT_W'(MAX_STACKS) : stack_cnt_ff;
   assign que_eff = (int'(queue_cnt_ff) > MAX_QUEUES) ? COUNT_W'(MAX_QUEUES) : queue_cnt_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en && req_vld) begin
         in_mode_ff   <= req_mode;
         in_target_ff <= req_target;
         in_word_ff   <= req_word;
      end
   end

   assign s_idx      = SIW'(in_target_ff);
   assign q_idx      = QIW'(in_target_ff);
   assign stk_bad    = int'(in_target_ff) >= int'(stk_eff);
   assign que_bad    = int'(in_target_ff) >= int'(que_eff);
   assign s_fill     = stack_fill_ff[s_idx];
   assign s_fill_dec = s_fill - FILL_W'(1);
   assign q_fill     = queue_fill_ff[q_idx];
   assign q_head     = queue_head_ff[q_idx];
   assign q_tail     = queue_tail_ff[q_idx];

   // Decision and next state
   always_comb begin
      stack_fill_in = stack_fill_ff;
      queue_head_in = queue_head_ff;
      queue_tail_in = queue_tail_ff;
      queue_fill_in = queue_fill_ff;
      op_in.vld     = in_vld_ff;
      op_in.rd_en   = 1'b0;
      op_in.wr_en   = 1'b0;
      op_in.status  = ST_OK;
      seg_idx_in    = SEG_IDX_W'(in_target_ff);
      offset_in     = '0;

      case (mode_type'(in_mode_ff))
         MODE_PUSH: begin
            if (stk_bad) begin
               op_in.status = ST_BAD;
            end else if (s_fill >= seg_eff) begin
               op_in.status = ST_FULL;
            end else begin
               op_in.wr_en          = 1'b1;
               offset_in            = s_fill[PTR_W-1:0];
               stack_fill_in[s_idx] = s_fill + FILL_W'(1);
            end
         end
         MODE_POP: begin
            if (stk_bad) begin
               op_in.status = ST_BAD;
            end else if (s_fill == '0) begin
               op_in.status = ST_EMPTY;
            end else begin
               op_in.rd_en          = 1'b1;
               offset_in            = s_fill_dec[PTR_W-1:0];
               stack_fill_in[s_idx] = s_fill_dec;
            end
         end
         MODE_ENQ: begin
            seg_idx_in = SEG_IDX_W'(int'(stk_eff) + int'(in_target_ff));
            if (que_bad) begin
               op_in.status = ST_BAD;
            end else if (q_fill >= seg_eff) begin
               op_in.status = ST_FULL;
            end else begin
               op_in.wr_en          = 1'b1;
               offset_in            = q_tail;
               queue_tail_in[q_idx] = ring_next(q_tail, seg_eff);
               queue_fill_in[q_idx] = q_fill + FILL_W'(1);
            end
         end
         MODE_DEQ: begin
            seg_idx_in = SEG_IDX_W'(int'(stk_eff) + int'(in_target_ff));
            if (que_bad) begin
               op_in.status = ST_BAD;
            end else if (q_fill == '0) begin
               op_in.status = ST_EMPTY;
            end else begin
               op_in.rd_en          = 1'b1;
               offset_in            = q_head;
               queue_head_in[q_idx] = ring_next(q_head, seg_eff);
               queue_fill_in[q_idx] = q_fill - FILL_W'(1);
            end
         end
         default: ;
      endcase
   end

   // State update, one request per enabled cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STACKS; i++) begin
            stack_fill_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_QUEUES; i++) begin
            queue_head_ff[i] <= '0;
            queue_tail_ff[i] <= '0;
            queue_fill_ff[i] <= '0;
         end
      end else if (en && in_vld_ff) begin
         stack_fill_ff <= stack_fill_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
         queue_fill_ff <= queue_fill_in;
      end
   end

   // Stage A output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0;
      end else if (en) begin
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_idx_ff <= seg_idx_in;
         offset_ff  <= offset_in;
         word_ff    <= in_word_ff;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/msqs_addr.sv
// Word address pipeline: segment base times size plus offset, reduced modulo depth.
`default_nettype none

module msqs_addr #(
   parameter int MEM_DEPTH = msqs_pkg::MEM_DEPTH_DEF,
   parameter int SEG_IDX_W = 4,
   parameter int ADDR_W    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  msqs_pkg::op_type                    op_a,
   input  logic [SEG_IDX_W-1:0]                seg_idx_a,
   input  logic [msqs_pkg::PTR_W-1:0]          offset_a,
   input  logic signed [msqs_pkg::WORD_W-1:0]  word_a,
   input  logic [msqs_pkg::SEG_W-1:0]          seg_eff,
   output msqs_pkg::op_type                    op_c,
   output logic [ADDR_W-1:0]                   addr_c,
   output logic signed [msqs_pkg::WORD_W-1:0]  word_c
);
   import msqs_pkg::*;

   // raw address < 2^(SEG_IDX_W+8): index * 256 + 255 at most
   localparam int RAW_W   = SEG_IDX_W + PTR_W;
   // reciprocal: q = floor(raw * RECIP / 2^SHIFT) is exact or one low
   localparam int SHIFT   = RAW_W + ADDR_W;
   localparam int PROD_W  = RAW_W + SHIFT;
   localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(MEM_DEPTH);
   localparam logic [SHIFT-1:0] RECIP = RECIP_FULL[SHIFT-1:0];
   localparam int DEPTH_W = ADDR_W + 1;
   localparam int QD_W    = RAW_W + DEPTH_W;

   op_type                   op_b_ff;
   logic [RAW_W-1:0]         raw_b_in;
   logic [RAW_W-1:0]         raw_b_ff;
   logic signed [WORD_W-1:0] word_b_ff;

   op_type                   op_c_ff;
   logic [PROD_W-1:0]        prod_b;
   logic [RAW_W-1:0]         q_c_in;
   logic [RAW_W-1:0]         q_c_ff;
   logic [RAW_W-1:0]         raw_c_ff;
   logic signed [WORD_W-1:0] word_c_ff;

   logic [QD_W-1:0]          qd_c;
   logic [RAW_W-1:0]         rem_c;
   logic [RAW_W-1:0]         rem_fix_c;

   // Stage B: base multiply plus offset
   assign raw_b_in = RAW_W'(RAW_W'(seg_idx_a) * RAW_W'(seg_eff)) + RAW_W'(offset_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_b_ff <= '0;
      end else if (en) begin
         op_b_ff <= op_a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raw_b_ff  <= raw_b_in;
         word_b_ff <= word_a;
      end
   end

   // Stage C: quotient estimate
   assign prod_b = PROD_W'(raw_b_ff) * PROD_W'(RECIP);
   assign q_c_in = prod_b[PROD_W-1:SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         op_c_ff <= '0;
      end else if (en) begin
         op_c_ff <= op_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_c_ff    <= q_c_in;
         raw_c_ff  <= raw_b_ff;
         word_c_ff <= word_b_ff;
      end
   end

   // Remainder with one correction step
   assign qd_c  = QD_W'(q_c_ff) * QD_W'(MEM_DEPTH);
   assign rem_c = raw_c_ff - qd_c[RAW_W-1:0];

   always_comb begin
      if (QD_W'(rem_c) >= QD_W'(MEM_DEPTH)) begin
         rem_fix_c = rem_c - RAW_W'(MEM_DEPTH);
      end else begin
         rem_fix_c = rem_c;
      end
   end

   assign op_c   = op_c_ff;
   assign addr_c = ADDR_W'(rem_fix_c);
   assign word_c = word_c_ff;

endmodule

`default_nettype wire

### hw/rtl/msqs_mem.sv
// Shared word memory and the response register.
`default_nettype none

module msqs_mem #(
   parameter int MEM_DEPTH = msqs_pkg::MEM_DEPTH_DEF,
   parameter int ADDR_W    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  msqs_pkg::op_type                    op_c,
   input  logic [ADDR_W-1:0]                   addr_c,
   input  logic signed [msqs_pkg::WORD_W-1:0]  word_c,
   output logic                                rsp_vld,
   output logic signed [msqs_pkg::WORD_W-1:0]  read_word,
   output logic [msqs_pkg::STATUS_W-1:0]       status
);
   import msqs_pkg::*;

   logic signed [WORD_W-1:0] mem [MEM_DEPTH];
   logic signed [WORD_W-1:0] rd_ff;
   logic                     vld_ff;
   logic                     use_ff;
   status_type               status_ff;

   always_ff @(posedge clock) begin
      if (en && op_c.vld && op_c.wr_en) begin
         mem[addr_c] <= word_c;
      end
      if (en && op_c.vld && op_c.rd_en) begin
         rd_ff <= mem[addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= op_c.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         use_ff    <= op_c.rd_en;
         status_ff <= op_c.status;
      end
   end

   assign rsp_vld   = vld_ff;
   assign read_word = use_ff ? rd_ff : '0;
   assign status    = status_ff;

endmodule

`default_nettype wire

### hw/rtl/multi_stack_queue_store.sv
// Top level: several stacks and queues in equal segments of one word memory.
//
// Requests arrive on req_chan (mode, target, write_word); each one yields
// exactly one transfer on rsp_chan (read_word, status) in request order.
// Stack s uses segment s, queue q uses segment stack_count+q; word addresses
// wrap modulo MEM_DEPTH when the segments do not fit.
// Config goes through csr_we/csr_idx/csr_data: 0 stack count, 1 queue count,
// 2 segment words. Write only while no request is in flight.
// Pipeline: input reg -> decide/update fills -> base multiply -> modulo
// quotient -> memory access + response reg. The response is valid once the
// request has passed all these registers; with rsp ready held high
// one request is taken and one response delivered every cycle.
// A response that is not taken freezes the whole pipeline; req_chan.ready
// then drops until the held transfer completes, so nothing is lost.
// Reset: fills and queue pointers clear, counts go to 1 and segment size to
// 128, pipeline empties. Memory contents are not cleared; after a change of
// stack count or segment size a pop can return a word that was never pushed.
`default_nettype none

module multi_stack_queue_store #(
   parameter int MEM_DEPTH  = msqs_pkg::MEM_DEPTH_DEF,
   parameter int MAX_STACKS = msqs_pkg::MAX_STACKS_DEF,
   parameter int MAX_QUEUES = msqs_pkg::MAX_QUEUES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   msqs_req_if.sink                         req_chan,
   msqs_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [msqs_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [msqs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import msqs_pkg::*;

   // segment index covers every stack plus every queue
   localparam int SEG_IDX_W = $clog2(MAX_STACKS + MAX_QUEUES);
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic                     en;        // pipeline advance
   logic                     rsp_vld;
   op_type                   op_a;
   op_type                   op_c;
   logic [SEG_IDX_W-1:0]     seg_idx_a;
   logic [PTR_W-1:0]         offset_a;
   logic signed [WORD_W-1:0] word_a;
   logic signed [WORD_W-1:0] word_c;
   logic [SEG_W-1:0]         seg_eff;
   logic [ADDR_W-1:0]        addr_c;

   // Everything moves unless a finished response is waiting on the sink
   assign en             = !rsp_vld || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = rsp_vld;

   msqs_ctrl #(
      .MAX_STACKS (MAX_STACKS),
      .MAX_QUEUES (MAX_QUEUES),
      .SEG_IDX_W  (SEG_IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_data   (csr_data),
      .req_vld    (req_chan.valid),
      .req_mode   (req_chan.mode),
      .req_target (req_chan.target),
      .req_word   (req_chan.write_word),
      .op_ff      (op_a),
      .seg_idx_ff (seg_idx_a),
      .offset_ff  (offset_a),
      .word_ff    (word_a),
      .seg_eff    (seg_eff)
   );

   msqs_addr #(
      .MEM_DEPTH (MEM_DEPTH),
      .SEG_IDX_W (SEG_IDX_W),
      .ADDR_W    (ADDR_W)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .op_a      (op_a),
      .seg_idx_a (seg_idx_a),
      .offset_a  (offset_a),
      .word_a    (word_a),
      .seg_eff   (seg_eff),
      .op_c      (op_c),
      .addr_c    (addr_c),
      .word_c    (word_c)
   );

   msqs_mem #(
      .MEM_DEPTH (MEM_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .op_c      (op_c),
      .addr_c    (addr_c),
      .word_c    (word_c),
      .rsp_vld   (rsp_vld),
      .read_word (rsp_chan.read_word),
      .status    (rsp_chan.status)
   );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the multi stack / queue store.
`timescale 1ns / 1ps

module testbench;
   import msqs_pkg::*;

   // One request as offered on the request channel
   typedef struct {
      mode_type             mode;
      logic [TARGET_W-1:0]  target;
      logic [WORD_W-1:0]    word;
   } req_item_type;

   // One response as seen on the response channel
   typedef struct {
      logic [WORD_W-1:0]  word;
      status_type         status;
   } rsp_item_type;

   // Directed script row: a register write or a request, with an optional
   // hand-written response
   typedef struct {
      bit                     is_reg;
      csr_idx_type            reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      req_item_type           req;
      bit                     typed;
      rsp_item_type           want;
   } script_row_type;

   localparam int DEPTH   = MEM_DEPTH_DEF;
   localparam int NSTACKS = MAX_STACKS_DEF;
   localparam int NQUEUES = MAX_QUEUES_DEF;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_idx;
   logic [CSR_DATA_W-1:0]  csr_data;

   msqs_req_if req_bus ();
   msqs_rsp_if rsp_bus ();

   multi_stack_queue_store dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_data (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the store: memory image, fill levels, ring pointers
   // and the three registers. mem_known marks words that were ever written;
   // reading any other word is something we must never provoke.
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0]  mem_image [DEPTH];
   bit                 mem_known [DEPTH];
   logic [FILL_W-1:0]  stk_fill  [NSTACKS];
   logic [PTR_W-1:0]   q_head    [NQUEUES];
   logic [PTR_W-1:0]   q_tail    [NQUEUES];
   logic [FILL_W-1:0]  q_fill    [NQUEUES];
   int unsigned        cfg_stacks, cfg_queues, cfg_seg;

   rsp_item_type  pending_rsps [$];   // responses still owed by the store
   int            requests_taken;     // request transfers so far
   int            responses_seen;
   int            status_seen [4];
   int            mismatches;
   int            reg_settings;

   // Counts above the maximum saturate.
   function automatic int unsigned stack_limit();
      return (cfg_stacks > NSTACKS) ? NSTACKS : cfg_stacks;
   endfunction

   function automatic int unsigned queue_limit();
      return (cfg_queues > NQUEUES) ? NQUEUES : cfg_queues;
   endfunction

   // Segment size 0 acts as 1, anything above SEG_MAX acts as SEG_MAX.
   function automatic int unsigned seg_len();
      if (cfg_seg == 0) return 1;
      return (cfg_seg > SEG_MAX) ? SEG_MAX : cfg_seg;
   endfunction

   // Oversized layouts simply wrap around the memory.
   function automatic int unsigned word_addr(int unsigned segment, int unsigned offset);
      return (segment * seg_len() + offset) % DEPTH;
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
      int unsigned n;
      n = p + 1;
      return (n >= seg_len()) ? '0 : n[PTR_W-1:0];
   endfunction

   // True when an accepted pop or dequeue would land on a never-written word.
   function automatic bit reads_unwritten(req_item_type r);
      int unsigned t;
      t = r.target;
      if (r.mode == MODE_POP && t < stack_limit() && stk_fill[t] != 0)
         return !mem_known[word_addr(t, stk_fill[t] - 1)];
      if (r.mode == MODE_DEQ && t < queue_limit() && q_fill[t] != 0)
         return !mem_known[word_addr(stack_limit() + t, q_head[t])];
      return 1'b0;
   endfunction

   // Apply one request to the shadow state and return the response it owes.
   function automatic rsp_item_type serve_request(req_item_type r);
      rsp_item_type o;
      int unsigned  t, seg, a;
      o.word   = '0;
      o.status = ST_OK;
      t        = r.target;
      seg      = seg_len();
      if (r.mode == MODE_PUSH || r.mode == MODE_POP) begin
         if (t >= stack_limit()) begin
            o.status = ST_BAD;
         end else if (r.mode == MODE_PUSH) begin
            if (stk_fill[t] >= seg) begin
               o.status = ST_FULL;
            end else begin
               a            = word_addr(t, stk_fill[t]);
               mem_image[a] = r.word;
               mem_known[a] = 1'b1;
               stk_fill[t]  = stk_fill[t] + 1'b1;
            end
         end else if (stk_fill[t] == 0) begin
            o.status = ST_EMPTY;
         end else begin
            stk_fill[t] = stk_fill[t] - 1'b1;
            o.word      = mem_image[word_addr(t, stk_fill[t])];
         end
      end else begin
         if (t >= queue_limit()) begin
            o.status = ST_BAD;
         end else if (r.mode == MODE_ENQ) begin
            if (q_fill[t] >= seg) begin
               o.status = ST_FULL;
            end else begin
               a            = word_addr(stack_limit() + t, q_tail[t]);
               mem_image[a] = r.word;
               mem_known[a] = 1'b1;
               q_tail[t]    = ring_next(q_tail[t]);
               q_fill[t]    = q_fill[t] + 1'b1;
            end
         end else if (q_fill[t] == 0) begin
            o.status = ST_EMPTY;
         end else begin
            o.word    = mem_image[word_addr(stack_limit() + t, q_head[t])];
            q_head[t] = ring_next(q_head[t]);
            q_fill[t] = q_fill[t] - 1'b1;
         end
      end
      return o;
   endfunction

   // No idling at all while this window of transfers goes by.
   function automatic bit calm_now();
      return requests_taken >= 700 && requests_taken < 900;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request, hold it until the transfer, then record what the
   // store owes for it. valid stays high when the next call follows at once.
   task automatic offer(req_item_type r, bit typed, rsp_item_type want);
      rsp_item_type predicted;
      while (!calm_now() && $urandom_range(0, 99) < 30) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      // A pop or dequeue that would read a never-written word turns into a write.
      if (reads_unwritten(r))
         r.mode = (r.mode == MODE_POP) ? MODE_PUSH : MODE_ENQ;
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= r.mode;
      req_bus.target     <= r.target;
      req_bus.write_word <= r.word;
      do
         @(posedge clock);
      while (!req_bus.ready);
      requests_taken++;
      predicted = serve_request(r);
      pending_rsps.push_back(typed ? want : predicted);
   endtask

   // Stop offering and wait until every response is back; the pipeline is
   // then empty of requests.
   task automatic drain_store();
      req_bus.valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; csr_we stays up when another write follows.
   task automatic write_reg(csr_idx_type idx, int unsigned val, bit more);
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_STACK_COUNT:   cfg_stacks = val & 4'hF;
         CSR_QUEUE_COUNT:   cfg_queues = val & 4'hF;
         CSR_SEGMENT_WORDS: cfg_seg    = val & 9'h1FF;
         default: ;
      endcase
      if (!more) csr_we <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Mostly well-aimed requests; one in ten goes to any index at all.
   function automatic req_item_type pick_request(int unsigned write_bias);
      req_item_type r;
      bit           on_stack, writes;
      int unsigned  lim;
      on_stack = $urandom_range(0, 1);
      writes   = $urandom_range(0, 99) < write_bias;
      if (on_stack) r.mode = writes ? MODE_PUSH : MODE_POP;
      else          r.mode = writes ? MODE_ENQ : MODE_DEQ;
      lim = on_stack ? stack_limit() : queue_limit();
      if (lim != 0 && $urandom_range(0, 9) != 0) r.target = $urandom_range(0, lim - 1);
      else                                        r.target = $urandom_range(0, 7);
      r.word = pick_word();
      return r;
   endfunction

   // New register setting, then a burst of requests with a random lean
   // toward writes or reads so that structures hit both full and empty.
   task automatic run_phase(int unsigned stacks, int unsigned queues,
                            int unsigned seg, int count);
      int unsigned   bias;
      rsp_item_type  none;
      none = '{word: '0, status: ST_OK};
      drain_store();
      write_reg(CSR_STACK_COUNT, stacks, 1'b1);
      write_reg(CSR_QUEUE_COUNT, queues, 1'b1);
      write_reg(CSR_SEGMENT_WORDS, seg, 1'b0);
      reg_settings++;
      bias = $urandom_range(35, 70);
      repeat (count) offer(pick_request(bias), 1'b0, none);
   endtask

   function automatic script_row_type op_row(mode_type m, int t, logic [WORD_W-1:0] w);
      script_row_type row;
      row.is_reg  = 1'b0;
      row.reg_idx = CSR_STACK_COUNT;
      row.reg_val = '0;
      row.req     = '{mode: m, target: t[TARGET_W-1:0], word: w};
      row.typed   = 1'b0;
      row.want    = '{word: '0, status: ST_OK};
      return row;
   endfunction

   function automatic script_row_type chk_row(mode_type m, int t, logic [WORD_W-1:0] w,
                                              logic [WORD_W-1:0] ew, status_type es);
      script_row_type row;
      row       = op_row(m, t, w);
      row.typed = 1'b1;
      row.want  = '{word: ew, status: es};
      return row;
   endfunction

   function automatic script_row_type reg_row(csr_idx_type idx, int v);
      script_row_type row;
      row         = op_row(MODE_PUSH, 0, '0);
      row.is_reg  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = v[CSR_DATA_W-1:0];
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      script_row_type  script [$];
      bit              more;
      for (int i = 0; i < DEPTH; i++) begin
         mem_image[i] = '0;
         mem_known[i] = 1'b0;
      end
      for (int i = 0; i < NSTACKS; i++) stk_fill[i] = '0;
      for (int i = 0; i < NQUEUES; i++) begin
         q_head[i] = '0;
         q_tail[i] = '0;
         q_fill[i] = '0;
      end
      cfg_stacks     = STACK_COUNT_RST;
      cfg_queues     = QUEUE_COUNT_RST;
      cfg_seg        = SEGMENT_WORDS_RST;
      requests_taken = 0;
      reg_settings   = 1;

      req_bus.valid      <= 1'b0;
      req_bus.mode       <= '0;
      req_bus.target     <= '0;
      req_bus.write_word <= '0;
      csr_we             <= 1'b0;
      csr_idx            <= '0;
      csr_data           <= '0;
      reset              <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset layout: one stack, one queue, 128-word segments.
      // Empty structures, out-of-range targets, extreme words, LIFO and
      // FIFO order.
      script.push_back(chk_row(MODE_POP,  0, '0, '0, ST_EMPTY));
      script.push_back(chk_row(MODE_DEQ,  0, '0, '0, ST_EMPTY));
      script.push_back(chk_row(MODE_PUSH, 1, 32'h1111_1111, '0, ST_BAD));
      script.push_back(chk_row(MODE_DEQ,  7, '0, '0, ST_BAD));
      script.push_back(chk_row(MODE_PUSH, 0, 32'h7FFF_FFFF, '0, ST_OK));
      script.push_back(chk_row(MODE_PUSH, 0, 32'h8000_0000, '0, ST_OK));
      script.push_back(chk_row(MODE_POP,  0, '0, 32'h8000_0000, ST_OK));
      script.push_back(chk_row(MODE_POP,  0, '0, 32'h7FFF_FFFF, ST_OK));
      script.push_back(chk_row(MODE_ENQ,  0, 32'hFFFF_FFFF, '0, ST_OK));
      script.push_back(chk_row(MODE_DEQ,  0, '0, 32'hFFFF_FFFF, ST_OK));
      // Zero segment acts as one word; counts above eight saturate.
      script.push_back(reg_row(CSR_SEGMENT_WORDS, 0));
      script.push_back(reg_row(CSR_STACK_COUNT, 15));
      script.push_back(reg_row(CSR_QUEUE_COUNT, 9));
      script.push_back(chk_row(MODE_PUSH, 7, '0, '0, ST_OK));
      script.push_back(chk_row(MODE_PUSH, 7, 32'h1234_5678, '0, ST_FULL));
      script.push_back(chk_row(MODE_ENQ,  7, 32'h0F0F_0F0F, '0, ST_OK));
      script.push_back(chk_row(MODE_ENQ,  7, 32'hF0F0_F0F0, '0, ST_FULL));
      script.push_back(chk_row(MODE_DEQ,  7, '0, 32'h0F0F_0F0F, ST_OK));
      script.push_back(chk_row(MODE_POP,  7, '0, '0, ST_OK));
      // Oversized segment clamps to 256: sixteen segments wrap the memory.
      script.push_back(reg_row(CSR_SEGMENT_WORDS, 511));
      script.push_back(reg_row(CSR_STACK_COUNT, 8));
      script.push_back(reg_row(CSR_QUEUE_COUNT, 8));
      script.push_back(op_row(MODE_PUSH, 1, 32'h1357_9BDF));
      script.push_back(op_row(MODE_ENQ,  0, 32'h2468_ACE0));
      script.push_back(op_row(MODE_POP,  1, '0));
      script.push_back(op_row(MODE_DEQ,  0, '0));
      // Segment shrinks below the fill: the stack counts as full, pops
      // still unwind it.
      script.push_back(op_row(MODE_PUSH, 0, 32'hCAFE_0001));
      script.push_back(op_row(MODE_PUSH, 0, 32'hCAFE_0002));
      script.push_back(reg_row(CSR_SEGMENT_WORDS, 1));
      script.push_back(chk_row(MODE_PUSH, 0, 32'hDEAD_BEEF, '0, ST_FULL));
      script.push_back(op_row(MODE_POP,  0, '0));
      script.push_back(op_row(MODE_POP,  0, '0));

      foreach (script[i]) begin
         if (script[i].is_reg) begin
            if (i == 0 || !script[i-1].is_reg) begin
               drain_store();
               reg_settings++;
            end
            more = (i + 1 < script.size()) && script[i+1].is_reg;
            write_reg(script[i].reg_idx, script[i].reg_val, more);
         end else begin
            offer(script[i].req, script[i].typed, script[i].want);
         end
      end

      // Fixed settings first (small rings, nothing in range, exact fit,
      // wraparound, clamping, one-word and zero-word segments), then random.
      run_phase(2, 2, 4, 100);
      run_phase(0, 0, 3, 40);
      run_phase(8, 8, 256, 100);
      run_phase(15, 15, 511, 100);
      run_phase(8, 8, 16, 100);
      run_phase(3, 5, 1, 100);
      run_phase(4, 4, 0, 100);
      repeat (8) begin
         run_phase($urandom_range(0, 15), $urandom_range(0, 15),
                   ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12)
                                               : $urandom_range(0, 511), 100);
      end

      drain_store();
      repeat (8) @(posedge clock);
      if (pending_rsps.size() != 0) mismatches++;

      $display("Ran %0d requests under %0d register settings.",
               requests_taken, reg_settings);
      $display("Responses: %0d ok, %0d empty, %0d full, %0d out of range.",
               status_seen[ST_OK], status_seen[ST_EMPTY],
               status_seen[ST_FULL], status_seen[ST_BAD]);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, one long hold-off so the
   // pipeline backs up into the request channel, and the checker.
   // ---------------------------------------------------------------------
   initial begin
      rsp_item_type  got, exp;
      int            stall_cycles_left;
      bit            held;
      stall_cycles_left = 0;
      held              = 1'b0;
      mismatches        = 0;
      responses_seen    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.word   = rsp_bus.read_word;
            got.status = status_type'(rsp_bus.status);
            responses_seen++;
            status_seen[got.status]++;
            if (pending_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: response %0d with nothing pending: word %h status %0d",
                           responses_seen, got.word, got.status);
            end else begin
               exp = pending_rsps.pop_front();
               if (got.word !== exp.word || got.status !== exp.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: response %0d: expected word %h status %0d,",
                               " got word %h status %0d"},
                              responses_seen, exp.word, exp.status, got.word, got.status);
               end
            end
         end
         if (stall_cycles_left > 0) begin
            stall_cycles_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held && requests_taken >= 450) begin
            held              = 1'b1;
            stall_cycles_left = 60;
            rsp_bus.ready    <= 1'b0;
         end else begin
            rsp_bus.ready <= calm_now() || $urandom_range(0, 99) >= 30;
         end
      end
   end

   // Watchdog: far beyond any correct run.
   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/msqs_pkg.sv
hw/rtl/msqs_if.sv
hw/rtl/msqs_ctrl.sv
hw/rtl/msqs_addr.sv
hw/rtl/msqs_mem.sv
hw/rtl/multi_stack_queue_store.sv
tb/testbench.sv
